### hw/rtl/rcnh_pkg.sv
// ----------------------------------------------------------------------------
// rcnh_pkg
// Shared widths, item types, state codes and the CORDIC step-angle table
// for the ray versus circle nearest hit unit.
// ----------------------------------------------------------------------------
package rcnh_pkg;

   localparam int MAX_CIRCLES  = 64;
   localparam int IDX_W        = $clog2(MAX_CIRCLES);
   localparam int CNT_W        = $clog2(MAX_CIRCLES + 1);

   localparam int POS_W        = 16;
   localparam int ANG_W        = 16;
   localparam int RAD_W        = 12;
   localparam int RNG_W        = 15;
   localparam int R2_W         = 2 * RAD_W;
   localparam int OUT_W        = 16;

   localparam int CORDIC_STEPS = 15;
   localparam int STEP_W       = 4;
   localparam int CORDIC_GAIN  = 9949;
   localparam int DIR_W        = 18;
   localparam int Z_W          = 17;

   localparam int DIFF_W       = 17;
   localparam int PRD_W        = DIFF_W + DIR_W;
   localparam int SQR_W        = 2 * DIFF_W;
   localparam int DOT_W        = PRD_W + 1;
   localparam int P_W          = 20;
   localparam int C_W          = 36;
   localparam int PP_W         = 2 * P_W;
   localparam int Q_W          = PP_W + 1;
   localparam int SQ_IN_W      = 36;
   localparam int SQ_OUT_W     = SQ_IN_W / 2;
   localparam int REM_W        = SQ_OUT_W + 4;
   localparam int T_W          = 21;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 15;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE  = 2'd1;

   localparam int REQ_DATA_W   = 48;

   typedef enum logic {
      KIND_ADD,
      KIND_QUERY
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic [ANG_W-1:0]          ray_angle;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_WALK,
      ST_DRAIN,
      ST_RESULT
   } back_state_type;

   function automatic logic signed [Z_W-1:0] step_angle(input logic [STEP_W-1:0] idx);
      logic signed [Z_W-1:0] a;
      unique case (idx)
         4'd0:    a = 17'sd8192;
         4'd1:    a = 17'sd4836;
         4'd2:    a = 17'sd2555;
         4'd3:    a = 17'sd1297;
         4'd4:    a = 17'sd651;
         4'd5:    a = 17'sd326;
         4'd6:    a = 17'sd163;
         4'd7:    a = 17'sd81;
         4'd8:    a = 17'sd41;
         4'd9:    a = 17'sd20;
         4'd10:   a = 17'sd10;
         4'd11:   a = 17'sd5;
         4'd12:   a = 17'sd3;
         default: a = 17'sd1;
      endcase
      return a;
   endfunction

endpackage

### hw/rtl/rcnh_front.sv
// ----------------------------------------------------------------------------
// rcnh_front
// Input side: takes request items, decodes the command and pushes a
// classified item into the command queue.
// ----------------------------------------------------------------------------
module rcnh_front (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rcnh_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   input  logic                             queue_full,
   output logic                             push,
   output rcnh_pkg::item_type               push_item
);
   import rcnh_pkg::*;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      push_item.kind      = req_tuser ? KIND_QUERY : KIND_ADD;
      push_item.pos_x     = $signed(req_tdata[15:0]);
      push_item.pos_y     = $signed(req_tdata[31:16]);
      push_item.ray_angle = req_tdata[47:32];
   end

endmodule

### hw/rtl/rcnh_queue.sv
// ----------------------------------------------------------------------------
// rcnh_queue
// Short FIFO of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module rcnh_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rcnh_pkg::item_type  push_item,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output rcnh_pkg::item_type  head_item
);
   import rcnh_pkg::*;

   item_type            store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;

   assign full      = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head_item = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hw/rtl/rcnh_back.sv
// ----------------------------------------------------------------------------
// rcnh_back
// Execution side: circle table, iterative CORDIC for the ray direction,
// a pipelined intersect path with a per-bit square-root pipeline, the
// running minimum and the result register.
// ----------------------------------------------------------------------------
module rcnh_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  rcnh_pkg::item_type            item,
   output logic                          item_pop,
   input  logic [rcnh_pkg::RAD_W-1:0]    circle_radius,
   input  logic [rcnh_pkg::RNG_W-1:0]    max_range,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rcnh_pkg::OUT_W-1:0]    rsp_tdata
);
   import rcnh_pkg::*;

   localparam int SQ_N = SQ_OUT_W + 1;

   back_state_type state_ff, state_in;

   // control
   logic                      pop, do_add, start_query, issue, walk_done, cordic_done;
   logic                      pipe_busy, load_rsp;

   // table
   logic [2*POS_W-1:0]        table_mem [MAX_CIRCLES];
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          walk_ff, walk_in;

   // query context
   logic signed [POS_W-1:0]   px_ff, py_ff;
   logic [R2_W-1:0]           r2_ff;
   logic                      flip_ff;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic signed [DIR_W-1:0]   x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [Z_W-1:0]     z_ff, z_in;
   logic signed [DIR_W-1:0]   dc_ff, ds_ff;
   logic [ANG_W-1:0]          ang_rot, ang_use;
   logic                      flip_in;

   // intersect pipeline
   logic                      rd_vld_ff;
   logic [2*POS_W-1:0]        rd_data_ff;
   logic                      s1_vld_ff;
   logic signed [DIFF_W-1:0]  cx_ff, cy_ff, cx_in, cy_in;
   logic                      s2_vld_ff;
   logic signed [PRD_W-1:0]   pcx_ff, pcy_ff, pcx_in, pcy_in;
   logic signed [SQR_W-1:0]   sxx_ff, syy_ff, sxx_in, syy_in;
   logic                      s3_vld_ff;
   logic signed [DOT_W-1:0]   dot, dot_sh;
   logic signed [P_W-1:0]     p3_ff, p3_in;
   logic signed [C_W-1:0]     c3_ff, c3_in;
   logic                      s4_vld_ff;
   logic signed [P_W-1:0]     p4_ff;
   logic signed [C_W-1:0]     c4_ff;
   logic signed [PP_W-1:0]    pp_ff, pp_in;
   logic signed [Q_W-1:0]     q_full;

   // square-root pipeline, entry 0 is the input stage
   logic                      sq_vld_ff  [SQ_N];
   logic                      sq_hit_ff  [SQ_N];
   logic signed [P_W-1:0]     sq_p_ff    [SQ_N];
   logic [SQ_IN_W-1:0]        sq_val_ff  [SQ_N];
   logic [REM_W-1:0]          sq_rem_ff  [SQ_N];
   logic [SQ_OUT_W-1:0]       sq_root_ff [SQ_N];
   logic [SQ_IN_W-1:0]        sq_val_in  [SQ_N];
   logic [REM_W-1:0]          sq_rem_in  [SQ_N];
   logic [SQ_OUT_W-1:0]       sq_root_in [SQ_N];
   logic                      sq_any;

   // minimum and result
   logic signed [T_W-1:0]     t1, best_ff, best_in;
   logic                      rsp_vld_ff, rsp_vld_in;
   logic [OUT_W-1:0]          rsp_data_ff, rsp_data_in;
   logic [OUT_W-1:0]          sat;

   // ---------------------------------------------------------------- FSM
   assign cordic_done = (step_ff == STEP_W'(CORDIC_STEPS - 1));
   assign walk_done   = (walk_ff == count_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (item_valid && item.kind == KIND_QUERY) state_in = ST_CORDIC;
         ST_CORDIC: if (cordic_done) state_in = ST_WALK;
         ST_WALK:   if (walk_done) state_in = ST_DRAIN;
         ST_DRAIN:  if (!pipe_busy) state_in = ST_RESULT;
         ST_RESULT: if (!rsp_vld_ff || rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop         = (state_ff == ST_IDLE) && item_valid;
      do_add      = pop && (item.kind == KIND_ADD) && (count_ff != CNT_W'(MAX_CIRCLES));
      start_query = pop && (item.kind == KIND_QUERY);
      issue       = (state_ff == ST_WALK) && !walk_done;
      load_rsp    = (state_ff == ST_RESULT) && (!rsp_vld_ff || rsp_tready);
   end

   assign item_pop = pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------- table
   always_comb begin
      count_in = do_add ? count_ff + 1'b1 : count_ff;
      walk_in  = start_query ? '0 : (issue ? walk_ff + 1'b1 : walk_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         walk_ff  <= '0;
      end else begin
         count_ff <= count_in;
         walk_ff  <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_add) begin
         table_mem[count_ff[IDX_W-1:0]] <= {item.pos_y, item.pos_x};
      end
      if (issue) begin
         rd_data_ff <= table_mem[walk_ff[IDX_W-1:0]];
      end
   end

   // ---------------------------------------------------------------- CORDIC
   always_comb begin
      ang_rot = item.ray_angle + 16'd16384;
      flip_in = ang_rot[ANG_W-1];
      ang_use = flip_in ? item.ray_angle + 16'd32768 : item.ray_angle;
      xs      = x_ff >>> step_ff;
      ys      = y_ff >>> step_ff;
      if (start_query) begin
         x_in    = DIR_W'(CORDIC_GAIN);
         y_in    = '0;
         z_in    = $signed({ang_use[ANG_W-1], ang_use});
         step_in = '0;
      end else if (state_ff == ST_CORDIC) begin
         if (!z_ff[Z_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - step_angle(step_ff);
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + step_angle(step_ff);
         end
         step_in = cordic_done ? step_ff : step_ff + 1'b1;
      end else begin
         x_in    = x_ff;
         y_in    = y_ff;
         z_in    = z_ff;
         step_in = step_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      if (start_query) begin
         px_ff   <= item.pos_x;
         py_ff   <= item.pos_y;
         flip_ff <= flip_in;
         r2_ff   <= circle_radius * circle_radius;
      end
      if (state_ff == ST_CORDIC && cordic_done) begin
         dc_ff <= flip_ff ? -x_in : x_in;
         ds_ff <= flip_ff ? -y_in : y_in;
      end
   end

   // ---------------------------------------------------------------- intersect
   always_comb begin
      cx_in  = $signed({px_ff[POS_W-1], px_ff})
             - $signed({rd_data_ff[POS_W-1], rd_data_ff[POS_W-1:0]});
      cy_in  = $signed({py_ff[POS_W-1], py_ff})
             - $signed({rd_data_ff[2*POS_W-1], rd_data_ff[2*POS_W-1:POS_W]});
      pcx_in = cx_ff * dc_ff;
      pcy_in = cy_ff * ds_ff;
      sxx_in = cx_ff * cx_ff;
      syy_in = cy_ff * cy_ff;
      // round from 14 fraction bits to an integer (Q20.0): add half then floor
      dot    = DOT_W'(pcx_ff) + DOT_W'(pcy_ff) + DOT_W'(8192);
      dot_sh = dot >>> 14;
      p3_in  = dot_sh[P_W-1:0];
      c3_in  = C_W'(sxx_ff) + C_W'(syy_ff) - C_W'($signed({1'b0, r2_ff}));
      pp_in  = p3_ff * p3_ff;
      q_full = Q_W'(pp_ff) - Q_W'(c4_ff);
   end

   always_ff @(posedge clock) begin
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      pcx_ff <= pcx_in;
      pcy_ff <= pcy_in;
      sxx_ff <= sxx_in;
      syy_ff <= syy_in;
      p3_ff  <= p3_in;
      c3_ff  <= c3_in;
      p4_ff  <= p3_ff;
      c4_ff  <= c3_ff;
      pp_ff  <= pp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
         s1_vld_ff <= rd_vld_ff;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   // ---------------------------------------------------------------- square root
   // one result bit per stage: bring down two radicand bits, try root*4+1
   always_comb begin
      logic [REM_W-1:0] rem_t;
      logic [REM_W-1:0] trial;
      sq_val_in[0]  = q_full[SQ_IN_W-1:0];
      sq_rem_in[0]  = '0;
      sq_root_in[0] = '0;
      for (int k = 0; k < SQ_OUT_W; k++) begin
         rem_t = {sq_rem_ff[k][REM_W-3:0], sq_val_ff[k][SQ_IN_W-1 -: 2]};
         trial = REM_W'({sq_root_ff[k], 2'b01});
         sq_val_in[k+1] = {sq_val_ff[k][SQ_IN_W-3:0], 2'b00};
         if (rem_t >= trial) begin
            sq_rem_in[k+1]  = rem_t - trial;
            sq_root_in[k+1] = {sq_root_ff[k][SQ_OUT_W-2:0], 1'b1};
         end else begin
            sq_rem_in[k+1]  = rem_t;
            sq_root_in[k+1] = {sq_root_ff[k][SQ_OUT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      sq_hit_ff[0] <= !q_full[Q_W-1];
      sq_p_ff[0]   <= p4_ff;
      for (int k = 0; k < SQ_N; k++) begin
         sq_val_ff[k]  <= sq_val_in[k];
         sq_rem_ff[k]  <= sq_rem_in[k];
         sq_root_ff[k] <= sq_root_in[k];
      end
      for (int k = 1; k < SQ_N; k++) begin
         sq_hit_ff[k] <= sq_hit_ff[k-1];
         sq_p_ff[k]   <= sq_p_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQ_N; k++) begin
            sq_vld_ff[k] <= 1'b0;
         end
      end else begin
         sq_vld_ff[0] <= s4_vld_ff;
         for (int k = 1; k < SQ_N; k++) begin
            sq_vld_ff[k] <= sq_vld_ff[k-1];
         end
      end
   end

   always_comb begin
      sq_any = 1'b0;
      for (int k = 0; k < SQ_N; k++) begin
         sq_any = sq_any | sq_vld_ff[k];
      end
      pipe_busy = rd_vld_ff | s1_vld_ff | s2_vld_ff | s3_vld_ff | s4_vld_ff | sq_any;
   end

   // ---------------------------------------------------------------- minimum
   always_comb begin
      t1 = -T_W'(sq_p_ff[SQ_N-1]) - T_W'($signed({1'b0, sq_root_ff[SQ_N-1]}));
      if (start_query) begin
         best_in = T_W'($signed({1'b0, max_range}));
      end else if (sq_vld_ff[SQ_N-1] && sq_hit_ff[SQ_N-1] && (t1 < best_ff)) begin
         best_in = t1;
      end else begin
         best_in = best_ff;
      end
      if (best_ff > T_W'(32767)) begin
         sat = 16'h7FFF;
      end else if (best_ff < -T_W'(32768)) begin
         sat = 16'h8000;
      end else begin
         sat = best_ff[OUT_W-1:0];
      end
      rsp_vld_in  = load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);
      rsp_data_in = load_rsp ? sat : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### hw/rtl/ray_circle_nearest_hit_unit.sv
// ----------------------------------------------------------------------------
// ray_circle_nearest_hit_unit
// Circle table with nearest-hit ray queries: front decoder, command queue
// and back end with CORDIC, pipelined intersect and square-root path.
// ----------------------------------------------------------------------------
// Add: popped from the queue while idle, no result.
// Query: runs the CORDIC loop, then one table read per cycle over the N
//   stored circles, then drains the 24-stage intersect and root pipeline
//   before the result is loaded.
// Items are worked one at a time; the queue takes up to 4 more meanwhile.
// Reset (synchronous, active high) empties the table and queue and loads
//   circle_radius = 16 and max_range = 5632; table contents are not cleared.
module ray_circle_nearest_hit_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pos_x [15:0], pos_y [31:16], ray_angle [47:32]
   input  logic [rcnh_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command [0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // hit_distance [15:0]
   output logic [rcnh_pkg::OUT_W-1:0]         rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rcnh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rcnh_pkg::CSR_DATA_W-1:0]    csr_data
);
   import rcnh_pkg::*;

   logic              push, queue_full, queue_pop, queue_nempty;
   item_type          push_item, head_item;
   logic [RAD_W-1:0]  radius_ff, radius_in;
   logic [RNG_W-1:0]  range_ff, range_in;

   assign csr_ready = 1'b1;

   always_comb begin
      radius_in = radius_ff;
      range_in  = range_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RADIUS: radius_in = csr_data[RAD_W-1:0];
            CSR_RANGE:  range_in  = csr_data[RNG_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RAD_W'(16);
         range_ff  <= RNG_W'(5632);
      end else begin
         radius_ff <= radius_in;
         range_ff  <= range_in;
      end
   end

   rcnh_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   rcnh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_nempty),
      .head_item (head_item)
   );

   rcnh_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (queue_nempty),
      .item          (head_item),
      .item_pop      (queue_pop),
      .circle_radius (radius_ff),
      .max_range     (range_ff),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

endmodule

### hw/rtl/rcnh_checker.sv
// ----------------------------------------------------------------------------
// rcnh_checker
// Port-level checks on the nearest hit unit, bound to the top level.
// ----------------------------------------------------------------------------
module rcnh_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [rcnh_pkg::REQ_DATA_W-1:0]    req_tdata,
   input logic                               req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [rcnh_pkg::OUT_W-1:0]         rsp_tdata,
   input logic                               csr_valid,
   input logic                               csr_ready,
   input logic [rcnh_pkg::CSR_IDX_W-1:0]     csr_index,
   input logic [rcnh_pkg::CSR_DATA_W-1:0]    csr_data
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_csr_always_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port not ready");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

bind ray_circle_nearest_hit_unit rcnh_checker u_rcnh_checker (.*);

### sim/tb_ray_circle_nearest_hit_unit.sv
// ----------------------------------------------------------------------------
// tb_ray_circle_nearest_hit_unit
// Self-checking bench for the ray versus circle nearest hit unit: adds and
// queries are driven under random idling on both sides, each query answer is
// predicted and compared in order with what the block returns.
// ----------------------------------------------------------------------------
module tb_ray_circle_nearest_hit_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import rcnh_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_3 = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [OUT_W-1:0]      rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // shadow of the block's state
   logic signed [POS_W-1:0] centre_x [MAX_CIRCLES];
   logic signed [POS_W-1:0] centre_y [MAX_CIRCLES];
   int                      n_circles;
   logic [RAD_W-1:0]        radius_q;
   logic [RNG_W-1:0]        range_q;

   logic signed [OUT_W-1:0] hit_queue [$];
   int  send_idle_pct;
   int  recv_idle_pct;
   int  stall_cycles;
   bit  failed;

   ray_circle_nearest_hit_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint r;
      longint b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void ray_direction(input logic [ANG_W-1:0] angle,
                                         output longint dc, output longint ds);
      logic [ANG_W-1:0] a;
      bit     flip;
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      a = angle;
      flip = 0;
      x = CORDIC_GAIN;
      y = 0;
      if (16'(a + 16'd16384) >= 16'd32768) begin
         a = a + 16'd32768;
         flip = 1;
      end
      z = longint'($signed(a));
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = floor_shr(x, i);
         ys = floor_shr(y, i);
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(step_angle(STEP_W'(i)));
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(step_angle(STEP_W'(i)));
         end
      end
      dc = flip ? -x : x;
      ds = flip ? -y : y;
   endfunction

   function automatic logic signed [OUT_W-1:0] nearest_hit(logic signed [POS_W-1:0] ox,
                                                           logic signed [POS_W-1:0] oy,
                                                           logic [ANG_W-1:0] angle);
      longint dc;
      longint ds;
      longint best;
      longint r2;
      longint cx;
      longint cy;
      longint p;
      longint c;
      longint q;
      longint t1;
      ray_direction(angle, dc, ds);
      best = longint'(range_q);
      r2 = longint'(radius_q) * longint'(radius_q);
      for (int i = 0; i < n_circles; i++) begin
         cx = longint'(ox) - longint'(centre_x[i]);
         cy = longint'(oy) - longint'(centre_y[i]);
         p = floor_shr(cx * dc + cy * ds + 8192, 14);
         c = cx * cx + cy * cy - r2;
         q = p * p - c;
         if (q >= 0) begin
            t1 = -p - int_sqrt(q);
            if (t1 < best) best = t1;
         end
      end
      if (best > 32767) best = 32767;
      if (best < -32768) best = -32768;
      return OUT_W'(best);
   endfunction

   // one item into the block; prediction made at the accepting edge
   task automatic send_item(kind_type kind, logic signed [POS_W-1:0] px,
                            logic signed [POS_W-1:0] py, logic [ANG_W-1:0] angle);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {angle, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == KIND_ADD) begin
         if (n_circles < MAX_CIRCLES) begin
            centre_x[n_circles] = px;
            centre_y[n_circles] = py;
            n_circles++;
         end
      end else begin
         hit_queue.insert(hit_queue.size(), nearest_hit(px, py, angle));
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_RADIUS) radius_q = value[RAD_W-1:0];
      else if (idx == CSR_RANGE) range_q = value[RNG_W-1:0];
   endtask

   // results are checked in order
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (hit_queue.size() == 0) begin
               $error("unexpected hit_distance item %0d", $signed(rsp_tdata));
               failed = 1;
            end else begin
               if (rsp_tdata !== hit_queue[0]) begin
                  $error("hit_distance expected %0d actual %0d",
                         hit_queue[0], $signed(rsp_tdata));
                  failed = 1;
               end
               void'(hit_queue.pop_front());
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic signed [POS_W-1:0] near_pos(int span);
      return POS_W'($urandom_range(2 * span) - span);
   endfunction

   task automatic test_registers();
      write_reg(CSR_UNUSED_2, 15'h7FFF);
      write_reg(CSR_UNUSED_3, 15'h1234);
      send_item(KIND_QUERY, 16'sd0, 16'sd0, 16'd0);
      wait_idle();
      write_reg(CSR_RADIUS, 15'd4095);
      write_reg(CSR_RANGE, 15'd32767);
      send_item(KIND_QUERY, -16'sd300, 16'sd7, 16'd100);
      wait_idle();
   endtask

   task automatic test_directed();
      // extremes of position, the four axis angles, a tie and huge roots
      send_item(KIND_ADD, 16'sd0, 16'sd0, 16'hFFFF);
      send_item(KIND_ADD, 16'sd0, 16'sd0, 16'd0);
      send_item(KIND_ADD, 16'sh7FFF, 16'sh7FFF, 16'd0);
      send_item(KIND_ADD, -16'sh8000, -16'sh8000, 16'd0);
      send_item(KIND_ADD, 16'sh7FFF, -16'sh8000, 16'd0);
      send_item(KIND_QUERY, -16'sd2000, 16'sd0, 16'd0);
      send_item(KIND_QUERY, 16'sd0, -16'sd2000, 16'd16384);
      send_item(KIND_QUERY, 16'sd2000, 16'sd0, 16'd32768);
      send_item(KIND_QUERY, 16'sd0, 16'sd2000, 16'd49152);
      send_item(KIND_QUERY, -16'sh8000, 16'sh7FFF, 16'hFFFF);
      send_item(KIND_QUERY, 16'sh7FFF, -16'sh8000, 16'd24576);
      send_item(KIND_QUERY, 16'sd0, 16'sd0, 16'd8192);
      wait_idle();
      write_reg(CSR_RADIUS, 15'd0);
      write_reg(CSR_RANGE, 15'd0);
      send_item(KIND_QUERY, -16'sd500, 16'sd0, 16'd0);
      send_item(KIND_QUERY, 16'sd500, 16'sd500, 16'd40000);
      wait_idle();
      write_reg(CSR_RADIUS, 15'd16);
      write_reg(CSR_RANGE, 15'd5632);
   endtask

   // clustered circles keep hits frequent; a few wild items use the full range
   task automatic test_random(int n_items);
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(9) == 0) begin
            px = POS_W'($urandom);
            py = POS_W'($urandom);
         end else begin
            px = near_pos(3000);
            py = near_pos(3000);
         end
         if ($urandom_range(3) == 0)
            send_item(KIND_ADD, px, py, ANG_W'($urandom));
         else
            send_item(KIND_QUERY, px, py, ANG_W'($urandom));
      end
      wait_idle();
   endtask

   task automatic test_full_table();
      while (n_circles < MAX_CIRCLES)
         send_item(KIND_ADD, near_pos(2000), near_pos(2000), 16'd0);
      send_item(KIND_ADD, 16'sd0, 16'sd0, 16'd0);
      send_item(KIND_ADD, 16'sd100, 16'sd100, 16'd0);
      for (int i = 0; i < 40; i++)
         send_item(KIND_QUERY, near_pos(2500), near_pos(2500), ANG_W'($urandom));
      wait_idle();
   endtask

   initial begin
      failed        = 0;
      n_circles     = 0;
      radius_q      = 12'd16;
      range_q       = 15'd5632;
      send_idle_pct = 27;
      recv_idle_pct = 83;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      rsp_tready <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_RADIUS;
      csr_data   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_registers();
      test_directed();
      test_random(300);
      send_idle_pct = 83;
      recv_idle_pct = 27;
      write_reg(CSR_RADIUS, 15'($urandom_range(4095)));
      write_reg(CSR_RANGE, 15'($urandom_range(32767)));
      test_random(250);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(CSR_RADIUS, 15'd600);
      test_full_table();
      write_reg(CSR_RADIUS, 15'($urandom_range(1500)));
      write_reg(CSR_RANGE, 15'd32767);
      test_random(340);

      wait_idle();
      if (!failed)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
